// File: rtl/brle_pkg.sv
// Package for the bit run-length encoder.
// Sizes, beat structs and scan / saturating-count helpers.
// No dependencies.
package brle_pkg;

   localparam int WORD_BITS     = 32;
   localparam int COUNT_BITS    = 32;
   localparam int DATA_BITS     = 32;
   localparam int LEN_BITS      = 32;
   localparam int LANE_BITS     = 8;
   localparam int LANES         = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
   localparam int PAD_BITS      = LANES * LANE_BITS;
   localparam int OFS_BITS      = $clog2(LANE_BITS);
   localparam int LANE_SEL_BITS = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int IDX_BITS      = $clog2(PAD_BITS);
   localparam int POS_BITS      = $clog2(WORD_BITS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic                hit;
      logic [OFS_BITS-1:0] ofs;
   } lane_hit_type;

   typedef struct packed {
      logic [PAD_BITS-1:0] pending;
      logic                final_word;
   } word_load_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] run_length;
      logic                run_value;
      logic                last_run;
   } run_beat_type;

   // scan order: index 0 is the word's top scanned bit
   function automatic logic [PAD_BITS-1:0] scan_seq(input logic [DATA_BITS-1:0] word);
      logic [PAD_BITS-1:0] seq;
      int                  src;
      seq = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
         src = WORD_BITS - 1 - k;
         if (src < DATA_BITS) begin
            seq[k] = word[src];
         end
      end
      return seq;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] base,
                                                     input logic [POS_BITS-1:0]   delta);
      logic [COUNT_BITS:0] sum;
      sum = (COUNT_BITS + 1)'(base) + (COUNT_BITS + 1)'(delta);
      if (sum[COUNT_BITS]) begin
         return COUNT_MAX;
      end
      return sum[COUNT_BITS-1:0];
   endfunction

   function automatic logic [LEN_BITS-1:0] len_field(input logic [COUNT_BITS-1:0] cnt);
      logic [127:0] wide;
      wide = 128'(cnt);
      return wide[LEN_BITS-1:0];
   endfunction

endpackage

// File: rtl/brle_lane.sv
// One search lane: finds the first pending bit change among its positions.
// Depends on brle_pkg.
module brle_lane (
   input  logic [brle_pkg::LANE_BITS-1:0] lane_bits,
   output brle_pkg::lane_hit_type         hit
);
   import brle_pkg::*;

   always_comb begin
      hit = '0;
      for (int i = LANE_BITS - 1; i >= 0; i--) begin
         if (lane_bits[i]) begin
            hit.hit = 1'b1;
            hit.ofs = OFS_BITS'(i);
         end
      end
   end

endmodule

// File: rtl/brle_serializer.sv
// Word slot, lane bank and merge: turns a word's bit changes into run beats,
// one per cycle into an output register while it is free. Depends on brle_pkg, brle_lane.
module brle_serializer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_valid,
   input  brle_pkg::word_load_type load,
   output logic                    load_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output brle_pkg::run_beat_type  out_beat
);
   import brle_pkg::*;

   logic                  busy_ff, busy_in;
   logic [PAD_BITS-1:0]   pending_ff, pending_in;
   logic                  final_ff, final_in;
   logic [COUNT_BITS-1:0] base_ff, base_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  val_ff, val_in;
   logic                  out_valid_ff, out_valid_in;
   run_beat_type          out_beat_ff, out_beat_in;

   lane_hit_type                    hits [LANES];
   logic                            any_hit;
   logic [LANE_SEL_BITS-1:0]        lane_sel;
   logic [OFS_BITS-1:0]             ofs;
   logic [LANE_SEL_BITS+OFS_BITS-1:0] k_full;
   logic [IDX_BITS-1:0]             k;
   logic                            out_free;
   logic                            emit;
   logic                            done;
   run_beat_type                    beat;
   logic [COUNT_BITS-1:0]           end_len;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      brle_lane u_lane (
         .lane_bits (pending_ff[l*LANE_BITS +: LANE_BITS]),
         .hit       (hits[l])
      );
   end

   // merge: lowest lane with a hit is first in scan order
   always_comb begin
      any_hit  = 1'b0;
      lane_sel = '0;
      ofs      = '0;
      for (int l = LANES - 1; l >= 0; l--) begin
         if (hits[l].hit) begin
            any_hit  = 1'b1;
            lane_sel = LANE_SEL_BITS'(l);
            ofs      = hits[l].ofs;
         end
      end
   end

   assign k_full   = {lane_sel, ofs};
   assign k        = k_full[IDX_BITS-1:0];
   assign out_free = !out_valid_ff || out_ready;
   assign end_len  = sat_add(base_ff, POS_BITS'(WORD_BITS) - pos_ff);

   always_comb begin
      busy_in    = busy_ff;
      pending_in = pending_ff;
      final_in   = final_ff;
      base_in    = base_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      emit       = 1'b0;
      done       = 1'b0;
      beat       = out_beat_ff;
      if (busy_ff) begin
         if (any_hit) begin
            if (out_free) begin
               emit            = 1'b1;
               beat.run_length = len_field(sat_add(base_ff, POS_BITS'(k) - pos_ff));
               beat.run_value  = val_ff;
               beat.last_run   = 1'b0;
               pending_in[k]   = 1'b0;
               base_in         = '0;
               pos_in          = POS_BITS'(k);
               val_in          = !val_ff;
            end
         end else if (final_ff) begin
            if (out_free) begin
               emit            = 1'b1;
               beat.run_length = len_field(end_len);
               beat.run_value  = val_ff;
               beat.last_run   = 1'b1;
               base_in         = '0;
               pos_in          = '0;
               val_in          = 1'b0;
               done            = 1'b1;
            end
         end else begin
            base_in = end_len;
            pos_in  = '0;
            done    = 1'b1;
         end
      end
      load_ready = !busy_ff || done;
      if (load_valid && load_ready) begin
         busy_in    = 1'b1;
         pending_in = load.pending;
         final_in   = load.final_word;
         pos_in     = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_beat_in  = out_beat_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_beat_in  = beat;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         base_ff      <= '0;
         pos_ff       <= '0;
         val_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         base_ff      <= base_in;
         pos_ff       <= pos_in;
         val_ff       <= val_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff  <= pending_in;
      final_ff    <= final_in;
      out_beat_ff <= out_beat_in;
   end

   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

endmodule

// File: rtl/bit_run_length_encoder.sv
// Bit run-length encoder, top level: bit-change detection on accept and
// the run serializer. Depends on brle_pkg, brle_serializer.
//
//   channel | ports | fields
//   input   | req_* | tdata: word, tlast: final_req
//   result  | rsp_* | tdata: run_length, tuser: run_value, tlast: last_run
//
// A word emits one run per bit change and is then closed (the closing step
// also emits the last run on a final word).
// The serializer emits one run per cycle while the result is not stalled; the
// lane search over the pending bit changes of the held word sets that figure.
// Reset is synchronous and returns to run value zero, count zero.
// A stalled result holds in the output register; the next word is taken
// in the cycle the held word closes.
module bit_run_length_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [brle_pkg::DATA_BITS-1:0] req_tdata,   // [31:0] word
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [brle_pkg::LEN_BITS-1:0]  rsp_tdata,   // [31:0] run_length
   output logic                           rsp_tuser,   // [0] run_value
   output logic                           rsp_tlast
);
   import brle_pkg::*;

   logic                cur_ff, cur_in;
   logic [PAD_BITS-1:0] seq;
   logic [PAD_BITS-1:0] changes;
   logic                prev;
   logic                accept;
   word_load_type       load;
   run_beat_type        beat;

   assign seq    = scan_seq(req_tdata);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      prev = cur_ff;
      for (int i = 0; i < PAD_BITS; i++) begin
         changes[i] = (i < WORD_BITS) && (seq[i] != prev);
         prev       = seq[i];
      end
   end

   assign load.pending    = changes;
   assign load.final_word = req_tlast;

   always_comb begin
      cur_in = cur_ff;
      if (accept) begin
         cur_in = req_tlast ? 1'b0 : seq[WORD_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= 1'b0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   brle_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_tvalid),
      .load       (load),
      .load_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_beat   (beat)
   );

   assign rsp_tdata = beat.run_length;
   assign rsp_tuser = beat.run_value;
   assign rsp_tlast = beat.last_run;

endmodule

// File: rtl/brle_checker.sv
// Port-level checks for the bit run-length encoder, bound to the top level.
// Depends on brle_pkg, bit_run_length_encoder.
module brle_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [brle_pkg::LEN_BITS-1:0]  rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           rsp_tlast
);
   import brle_pkg::*;

   logic exp_val_ff, exp_val_in;
   logic narrow_count;

   assign narrow_count = (COUNT_BITS <= LEN_BITS);

   always_comb begin
      exp_val_in = exp_val_ff;
      if (rsp_tvalid && rsp_tready) begin
         exp_val_in = rsp_tlast ? 1'b0 : !rsp_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_val_ff <= 1'b0;
      end else begin
         exp_val_ff <= exp_val_in;
      end
   end

   a_no_beat_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_run_values_alternate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == exp_val_ff)
      else $error("run value out of sequence");

   a_empty_run_first_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && narrow_count && rsp_tdata == '0 |-> !rsp_tuser && !rsp_tlast)
      else $error("empty run other than a leading run of zeros");

endmodule

bind bit_run_length_encoder brle_checker u_brle_checker (.*);
